FILE: rtl/core/rau_pkg.sv
// Package with the operation codes, status codes and controller types of the rational unit.
package rau_pkg;

    localparam int unsigned MAG_BITS = 64;

    typedef enum logic [3:0] {
        OP_NORM = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_NEG  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_CMP  = 4'd8
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD_START,
        S_MOD,
        S_DIV_NUM,
        S_DIV_DEN,
        S_CHECK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic comb;
        logic gcd_init;
        logic mod_start;
        logic mod_to_gcd;
        logic div_num_start;
        logic div_num_done;
        logic div_den_start;
        logic div_den_done;
        logic check;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic zero_num;
        logic gcd_done;
        logic div_busy;
    } t_status;

endpackage

FILE: rtl/core/rau_divider.sv
// Shared restoring divider, one quotient bit per cycle, for the GCD and the final reduction.
module rau_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::MAG_BITS-1:0] i_dividend,
    input  logic [rau_pkg::MAG_BITS-1:0] i_divisor,
    output logic                       o_busy,
    output logic [rau_pkg::MAG_BITS-1:0] o_quot,
    output logic [rau_pkg::MAG_BITS-1:0] o_rem
);
    import rau_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(MAG_BITS + 1);

    logic [MAG_BITS-1:0] r_q, n_q;
    logic [MAG_BITS-1:0] r_rem, n_rem;
    logic [MAG_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [MAG_BITS:0]   w_trial;
    logic [MAG_BITS:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_q[MAG_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_q     = {r_q[MAG_BITS-2:0], 1'b0};
        n_rem   = w_trial[MAG_BITS-1:0];
        if (!w_diff[MAG_BITS]) begin
            n_rem   = w_diff[MAG_BITS-1:0];
            n_q[0]  = 1'b1;
        end
        n_cnt = r_cnt - CNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(MAG_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/rau_datapath.sv
// Datapath: operand magnitudes, cross products, signed sum, GCD registers and result checks.
module rau_datapath #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rau_pkg::t_cmd i_cmd,
    input  logic [3:0]    i_kind,
    input  logic [31:0]   i_a_num,
    input  logic [31:0]   i_a_den,
    input  logic [31:0]   i_b_num,
    input  logic [31:0]   i_b_den,
    output rau_pkg::t_status o_stat,
    output logic [31:0]   o_res_num,
    output logic [30:0]   o_res_den,
    output logic [1:0]    o_order,
    output logic [1:0]    o_status
);
    import rau_pkg::*;

    localparam int unsigned HB = WORD_BITS;

    logic [3:0]          r_kind;
    logic                r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [HB-1:0]       r_an, r_ad, r_bn, r_bd;
    logic [MAG_BITS-1:0] r_p1, r_p2, r_p3;
    logic                r_neg;
    logic [MAG_BITS-1:0] r_num, r_den;
    logic [MAG_BITS-1:0] r_gx, r_gy;
    logic                r_early;
    logic [1:0]          r_order, r_status;
    logic [31:0]         r_out_num;
    logic [30:0]         r_out_den;

    logic [MAG_BITS-1:0] w_div_a, w_div_b, w_quot, w_rem;
    logic                w_div_start, w_busy;

    function automatic logic [HB:0] f_mag(input logic [31:0] v);
        logic [HB-1:0] w;
        logic [HB-1:0] m;
        w = v[HB-1:0];
        m = w[HB-1] ? (~w + HB'(1)) : w;
        return {w[HB-1], m};
    endfunction

    logic [HB:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = f_mag(i_a_num);
    assign w_ad = f_mag(i_a_den);
    assign w_bn = f_mag(i_b_num);
    assign w_bd = f_mag(i_b_den);

    logic w_uses_b, w_zero;
    always_comb begin
        w_uses_b = (i_kind == OP_ADD) || (i_kind == OP_SUB) || (i_kind == OP_MUL) ||
                   (i_kind == OP_DIV) || (i_kind == OP_CMP);
        w_zero = (w_ad[HB-1:0] == '0) || (w_uses_b && w_bd[HB-1:0] == '0) ||
                 (i_kind == OP_DIV && w_bn[HB-1:0] == '0);
    end

    logic a_neg, b_neg, sb, is_addsub;
    logic [MAG_BITS:0] w_sum;
    logic [MAG_BITS-1:0] w_mag;
    logic w_sgn;
    always_comb begin
        a_neg = (r_an != '0) && (r_an_s != r_ad_s);
        b_neg = (r_bn != '0) && (r_bn_s != r_bd_s);
        is_addsub = (r_kind == OP_ADD) || (r_kind == OP_SUB) ||
                    (r_kind == OP_INC) || (r_kind == OP_DEC) || (r_kind == OP_CMP);
        sb = b_neg;
        if (r_kind == OP_SUB || r_kind == OP_DEC || r_kind == OP_CMP) begin
            sb = (r_bn != '0) && !b_neg;
        end
        if (a_neg == sb) begin
            w_sum = {1'b0, r_p1} + {1'b0, r_p2};
            w_mag = w_sum[MAG_BITS-1:0];
            w_sgn = a_neg;
        end else if (r_p1 >= r_p2) begin
            w_sum = {1'b0, r_p1} - {1'b0, r_p2};
            w_mag = w_sum[MAG_BITS-1:0];
            w_sgn = a_neg;
        end else begin
            w_sum = {1'b0, r_p2} - {1'b0, r_p1};
            w_mag = w_sum[MAG_BITS-1:0];
            w_sgn = sb;
        end
        if (w_mag == '0) begin
            w_sgn = 1'b0;
        end
    end

    assign w_div_start = i_cmd.mod_start || i_cmd.div_num_start || i_cmd.div_den_start;
    always_comb begin
        w_div_a = r_gx;
        w_div_b = r_gy;
        if (i_cmd.div_num_start) begin
            w_div_a = r_num;
            w_div_b = r_gx;
        end else if (i_cmd.div_den_start) begin
            w_div_a = r_den;
            w_div_b = r_gx;
        end
    end

    rau_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_div_a),
        .i_divisor (w_div_b),
        .o_busy    (w_busy),
        .o_quot    (w_quot),
        .o_rem     (w_rem)
    );

    logic [MAG_BITS-1:0] w_lim;
    logic w_ovf;
    assign w_lim = MAG_BITS'(1) << (HB - 1);
    assign w_ovf = (r_den > w_lim - MAG_BITS'(1)) ||
                   (r_num > (r_neg ? w_lim : w_lim - MAG_BITS'(1)));

    logic [MAG_BITS-1:0] w_sres;
    assign w_sres = r_neg ? (~r_num + MAG_BITS'(1)) : r_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            {r_an_s, r_an} <= w_an;
            {r_ad_s, r_ad} <= w_ad;
            if (i_kind == OP_INC || i_kind == OP_DEC) begin
                {r_bn_s, r_bn} <= {1'b0, HB'(1)};
                {r_bd_s, r_bd} <= {1'b0, HB'(1)};
            end else begin
                {r_bn_s, r_bn} <= w_bn;
                {r_bd_s, r_bd} <= w_bd;
            end
            r_early   <= w_zero;
            r_order   <= ORD_LT;
            r_status  <= w_zero ? ST_ZERO : ST_OK;
            r_out_num <= '0;
            r_out_den <= '0;
        end
        if (i_cmd.mul) begin
            if (r_kind == OP_DIV) begin
                r_p1 <= MAG_BITS'(r_an) * MAG_BITS'(r_bd);
                r_p2 <= MAG_BITS'(r_ad) * MAG_BITS'(r_bn);
            end else if (r_kind == OP_MUL) begin
                r_p1 <= MAG_BITS'(r_an) * MAG_BITS'(r_bn);
                r_p2 <= MAG_BITS'(r_ad) * MAG_BITS'(r_bd);
            end else begin
                r_p1 <= MAG_BITS'(r_an) * MAG_BITS'(r_bd);
                r_p2 <= MAG_BITS'(r_bn) * MAG_BITS'(r_ad);
            end
            r_p3 <= MAG_BITS'(r_ad) * MAG_BITS'(r_bd);
        end
        if (i_cmd.comb) begin
            if (r_kind == OP_CMP) begin
                r_order <= (w_mag == '0) ? ORD_EQ : (w_sgn ? ORD_LT : ORD_GT);
                r_early <= 1'b1;
            end else if (is_addsub) begin
                r_num <= w_mag;
                r_den <= r_p3;
                r_neg <= w_sgn;
            end else if (r_kind == OP_MUL || r_kind == OP_DIV) begin
                r_num <= r_p1;
                r_den <= r_p2;
                r_neg <= (r_p1 != '0) && (a_neg != b_neg);
            end else if (r_kind == OP_NEG) begin
                r_num <= MAG_BITS'(r_an);
                r_den <= MAG_BITS'(r_ad);
                r_neg <= (r_an != '0) && !a_neg;
            end else begin
                r_num <= MAG_BITS'(r_an);
                r_den <= MAG_BITS'(r_ad);
                r_neg <= a_neg;
            end
        end
        if (i_cmd.gcd_init) begin
            if (r_num == '0) begin
                r_den <= MAG_BITS'(1);
                r_neg <= 1'b0;
            end
            r_gx <= r_num;
            r_gy <= r_den;
        end
        if (i_cmd.mod_to_gcd) begin
            r_gx <= r_gy;
            r_gy <= w_rem;
        end
        if (i_cmd.div_num_done) begin
            r_num <= w_quot;
        end
        if (i_cmd.div_den_done) begin
            r_den <= w_quot;
        end
        if (i_cmd.check) begin
            if (w_ovf) begin
                r_status <= ST_OVF;
            end else begin
                r_out_num <= w_sres[31:0];
                r_out_den <= r_den[30:0];
            end
        end
    end

    assign o_stat.early    = r_early;
    assign o_stat.zero_num = (r_num == '0);
    assign o_stat.gcd_done = (r_gy == '0);
    assign o_stat.div_busy = w_busy;
    assign o_res_num = r_out_num;
    assign o_res_den = r_out_den;
    assign o_order   = r_order;
    assign o_status  = r_status;

endmodule

FILE: rtl/core/rau_ctrl.sv
// Controller state machine that sequences one operation through the datapath.
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_fire,
    input  rau_pkg::t_status i_stat,
    output rau_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_fire) n_state = S_MUL;
            S_MUL:       n_state = i_stat.early ? S_OUT : S_COMB;
            S_COMB:      n_state = S_GCD_START;
            S_GCD_START: begin
                if (i_stat.early || i_stat.zero_num) begin
                    n_state = i_stat.early ? S_OUT : S_CHECK;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_stat.div_busy) begin
                    n_state = i_stat.gcd_done ? S_DIV_NUM : S_MOD;
                end
            end
            S_DIV_NUM:   if (!i_stat.div_busy) n_state = S_DIV_DEN;
            S_DIV_DEN:   if (!i_stat.div_busy) n_state = S_CHECK;
            S_CHECK:     n_state = S_OUT;
            S_OUT:       if (i_out_fire) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // The divider is started by a command from this controller, and its busy flag then
    // drops when the result is ready; r_go marks that the start was issued.
    logic r_go, n_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= n_go;
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_go        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            S_MUL:  o_cmd.mul = 1'b1;
            S_COMB: o_cmd.comb = 1'b1;
            S_GCD_START: o_cmd.gcd_init = 1'b1;
            S_MOD: begin
                if (!r_go) begin
                    if (!i_stat.gcd_done) begin
                        o_cmd.mod_start = 1'b1;
                        n_go = 1'b1;
                    end else begin
                        o_cmd.div_num_start = 1'b1;
                        n_go = 1'b1;
                    end
                end else if (!i_stat.div_busy) begin
                    o_cmd.mod_to_gcd = 1'b1;
                end else begin
                    n_go = 1'b1;
                end
            end
            S_DIV_NUM: begin
                if (!r_go) begin
                    n_go = 1'b1;
                end else if (!i_stat.div_busy) begin
                    o_cmd.div_num_done = 1'b1;
                    o_cmd.div_den_start = 1'b1;
                    n_go = 1'b1;
                end else begin
                    n_go = 1'b1;
                end
            end
            S_DIV_DEN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_den_done = 1'b1;
                end else begin
                    n_go = 1'b1;
                end
            end
            S_CHECK: o_cmd.check = 1'b1;
            S_OUT:   o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mod_start, o_cmd.div_den_start, o_cmd.load}))
        else $error("more than one unit start in a cycle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("operand load outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_fire) |=> o_out_valid)
        else $error("result dropped before transfer");

endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit with stream ports.
//
// One input transfer on the s_axis side carries an operation code and two
// fractions; one output transfer on the m_axis side returns the reduced
// result and the compare order in tdata and the status code in tuser. Items
// are handled one at a time: s_axis_tready is high only while the unit is idle.
// The shared 64-bit restoring divider takes one quotient bit per cycle. A
// zero-denominator item goes from the multiply state straight to the output,
// a compare from the GCD start state, and a zero result through the check
// state. Any other item passes the multiply, combine and GCD start states,
// one divider run per Euclid step of the GCD, the two final divisions and a
// check state before its result is valid.
// The result register holds its value while m_axis_tready is low, and the next
// input is taken from the cycle after the output transfer.
// Reset (synchronous, active low) returns the controller to idle and
// drops any item in progress.
module rational_arithmetic_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [3:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // res_num, res_den (31), order, zero padding
    output logic [1:0]   m_axis_tuser   // status
);
    import rau_pkg::*;

    t_cmd    w_cmd;
    t_status w_stat;
    logic    w_in_fire, w_out_fire;
    logic [31:0] w_res_num;
    logic [30:0] w_res_den;
    logic [1:0]  w_order, w_status;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_fire (w_out_fire),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_kind   (s_axis_tuser),
        .i_a_num  (s_axis_tdata[31:0]),
        .i_a_den  (s_axis_tdata[63:32]),
        .i_b_num  (s_axis_tdata[95:64]),
        .i_b_den  (s_axis_tdata[127:96]),
        .o_stat   (w_stat),
        .o_res_num(w_res_num),
        .o_res_den(w_res_den),
        .o_order  (w_order),
        .o_status (w_status)
    );

    assign m_axis_tdata = {7'd0, w_order, w_res_den, w_res_num};
    assign m_axis_tuser = w_status;

endmodule

FILE: tb/rational_arithmetic_unit_tb.sv
// Self-checking testbench for the rational arithmetic unit, with directed and random stimulus.
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  order;
        logic [1:0]  status;
    } t_fraction_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // a_num, a_den, b_num, b_den
    logic [3:0]   s_axis_tuser = '0;   // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;        // res_num, res_den, order, zero padding
    logic [1:0]   m_axis_tuser;        // status

    t_fraction_result reduced_q[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  idling_on = 1'b1;

    rational_arithmetic_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned magnitude(logic signed [31:0] x);
        longint signed w;
        w = x;
        return (w < 0) ? longint'(-w) : longint'(w);
    endfunction

    function automatic t_fraction_result reduce_fraction(logic [3:0] kind,
            logic signed [31:0] an, logic signed [31:0] ad,
            logic signed [31:0] bn, logic signed [31:0] bd);
        t_fraction_result r;
        longint unsigned am, adm, bm, bdm, rn, rd, x, y, t, p1, p2;
        bit a_neg, b_neg, r_neg, s2, uses_b;
        r = '0;
        am = magnitude(an);
        adm = magnitude(ad);
        bm = magnitude(bn);
        bdm = magnitude(bd);
        a_neg = (am != 0) && ((an < 0) != (ad < 0));
        b_neg = (bm != 0) && ((bn < 0) != (bd < 0));
        uses_b = (kind >= OP_ADD && kind <= OP_DIV) || kind == OP_CMP;
        if (adm == 0 || (uses_b && bdm == 0) || (kind == OP_DIV && bm == 0)) begin
            r.status = ST_ZERO;
            return r;
        end
        if (kind == OP_INC || kind == OP_DEC) begin
            b_neg = 1'b0;
            bm = 1;
            bdm = 1;
        end
        rn = am;
        rd = adm;
        r_neg = a_neg;
        case (kind)
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_CMP: begin
                s2 = b_neg;
                if (kind == OP_SUB || kind == OP_DEC || kind == OP_CMP) begin
                    s2 = (bm != 0) && !b_neg;
                end
                p1 = am * bdm;
                p2 = bm * adm;
                if (a_neg == s2) begin
                    rn = p1 + p2;
                    r_neg = a_neg;
                end else if (p1 >= p2) begin
                    rn = p1 - p2;
                    r_neg = a_neg;
                end else begin
                    rn = p2 - p1;
                    r_neg = s2;
                end
                if (rn == 0) r_neg = 1'b0;
                if (kind == OP_CMP) begin
                    r.order = (rn == 0) ? ORD_EQ : (r_neg ? ORD_LT : ORD_GT);
                    return r;
                end
                rd = adm * bdm;
            end
            OP_MUL: begin
                rn = am * bm;
                rd = adm * bdm;
                r_neg = (rn != 0) && (a_neg != b_neg);
            end
            OP_DIV: begin
                rn = am * bdm;
                rd = adm * bm;
                r_neg = (rn != 0) && (a_neg != b_neg);
            end
            OP_NEG: r_neg = (rn != 0) && !r_neg;
            default: ;
        endcase
        if (rn == 0) begin
            rd = 1;
            r_neg = 1'b0;
        end else begin
            x = rn;
            y = rd;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            rn = rn / x;
            rd = rd / x;
        end
        if (rd > 64'h7FFF_FFFF || rn > (r_neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.status = ST_OVF;
            return r;
        end
        r.res_num = r_neg ? 32'(-rn) : 32'(rn);
        r.res_den = 31'(rd);
        return r;
    endfunction

    task automatic send_item(logic [3:0] kind, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_axis_tready);
        reduced_q.push_back(reduce_fraction(kind, an, ad, bn, bd));
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 2000)) - 1000);
            3:       return 32'd0;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic logic [31:0] random_den();
        logic [31:0] v;
        v = random_word();
        if (v == 0 && $urandom_range(0, 7) != 0) v = 32'd1;
        return v;
    endfunction

    task automatic test_extremes();
        send_item(OP_NORM, 32'h8000_0000, 32'h0000_0001, 32'd0, 32'd1);
        send_item(OP_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1);
        send_item(OP_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1);
        send_item(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(OP_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
    endtask

    task automatic test_operations();
        for (int k = OP_NORM; k <= OP_CMP; k++) begin
            send_item(4'(k), 32'd6, 32'hFFFF_FFFC, 32'd3, 32'd9);
        end
        send_item(OP_CMP, 32'd2, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
        send_item(OP_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_item(OP_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    endtask

    task automatic test_special_cases();
        send_item(OP_SUB, 32'd5, 32'd7, 32'hFFFF_FFFB, 32'hFFFF_FFF9);
        send_item(OP_NORM, 32'd3, 32'd0, 32'd1, 32'd1);
        send_item(OP_ADD, 32'd3, 32'd4, 32'd1, 32'd0);
        send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        send_item(OP_NEG, 32'd0, 32'hFFFF_FFF0, 32'd0, 32'd0);
        send_item(4'd9, 32'd10, 32'd4, 32'd0, 32'd0);
        send_item(4'd15, 32'hFFFF_FFF6, 32'd4, 32'd1, 32'd0);
        send_item(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    endtask

    task automatic test_random(int count);
        logic [3:0] kind;
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            send_item(kind, random_word(), random_den(), random_word(), random_den());
        end
    endtask

    always @(posedge i_clk) begin
        if (!idling_on) begin
            m_axis_tready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            m_axis_tready <= (idle_cycles == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            idle_cycles <= $urandom_range(1, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_fraction_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reduced_q.size() == 0) begin
                $error("unexpected result transfer");
                error_count++;
            end else begin
                exp_r = reduced_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.res_num) begin
                    $error("res_num expected %0d actual %0d",
                           $signed(exp_r.res_num), $signed(m_axis_tdata[31:0]));
                    error_count++;
                end
                if (m_axis_tdata[62:32] !== exp_r.res_den) begin
                    $error("res_den expected %0d actual %0d",
                           exp_r.res_den, m_axis_tdata[62:32]);
                    error_count++;
                end
                if (m_axis_tdata[64:63] !== exp_r.order) begin
                    $error("order expected %0d actual %0d",
                           exp_r.order, m_axis_tdata[64:63]);
                    error_count++;
                end
                if (m_axis_tuser !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_operations();
        test_special_cases();
        test_random(900);
        idling_on = 1'b0;
        test_random(125);
        s_axis_tvalid <= 1'b0;
        while (reduced_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
